>>> design/obbcp_pkg.sv
// shared types and constants for the obb closest point block
package obbcp_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int AXIS_FRAC_BITS_DEF = 14;
    localparam int CFG_IDX_W          = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_CENTER   = 3'd0,
        REG_AXIS_RIGHT   = 3'd1,
        REG_AXIS_UP      = 3'd2,
        REG_AXIS_FORWARD = 3'd3,
        REG_HALF_EXTENTS = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        N_IDLE,
        N_SQRT,
        N_LOAD,
        N_DIV
    } norm_state_t;

    typedef struct packed {
        logic       start;
        logic [1:0] axis;
    } norm_cmd_t;

endpackage

>>> design/obbcp_norm.sv
// axis normalizer: iterative square root and restoring division, holds unit axes
module obbcp_norm
    import obbcp_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  norm_cmd_t                              cmd,
    input  logic [3*(AXIS_FRAC_BITS+2)-1:0]        axis_data,
    output logic                                   busy,
    output logic [2:0][2:0][AXIS_FRAC_BITS+1:0]    unit_axes
);

    localparam int AF   = AXIS_FRAC_BITS;
    localparam int AW   = AF + 2;
    localparam int NNW  = 2 * AW;
    localparam int XW   = NNW + 16;
    localparam int SW   = XW / 2;
    localparam int NW   = 2 * AF + 11;
    localparam int SQC_W = $clog2(SW);
    localparam int DVC_W = $clog2(NW);
    localparam logic [SQC_W-1:0] SQ_LAST = SQC_W'(SW - 1);
    localparam logic [DVC_W-1:0] DV_LAST = DVC_W'(NW - 1);

    norm_state_t state_reg, state_next;

    logic [3*AW-1:0]   raw_reg;
    logic [1:0]        axis_reg;
    logic [1:0]        comp_reg;
    logic [XW-1:0]     x_reg, res_reg, bit_reg;
    logic [SQC_W-1:0]  sq_cnt_reg;
    logic [DVC_W-1:0]  dv_cnt_reg;
    logic [NW-1:0]     num_reg, quo_reg;
    logic [SW-1:0]     rem_reg;
    logic [2:0][2:0][AW-1:0] u_reg;

    // sum of squares of the incoming axis
    logic signed [AW-1:0] a_in [3];
    logic [NNW-1:0]       n_in;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            a_in[i] = $signed(axis_data[i*AW +: AW]);
        n_in = NNW'($signed(NNW'(a_in[0])) * $signed(NNW'(a_in[0])))
             + NNW'($signed(NNW'(a_in[1])) * $signed(NNW'(a_in[1])))
             + NNW'($signed(NNW'(a_in[2])) * $signed(NNW'(a_in[2])));
    end

    // one square root step
    logic [XW-1:0] sq_t, x_step, res_step;
    always_comb
    begin
        sq_t = res_reg + bit_reg;
        if (x_reg >= sq_t)
        begin
            x_step   = x_reg - sq_t;
            res_step = (res_reg >> 1) + bit_reg;
        end
        else
        begin
            x_step   = x_reg;
            res_step = res_reg >> 1;
        end
    end

    // dividend for the selected component
    logic [SW-1:0]        s_val;
    logic signed [AW-1:0] a_sel;
    logic                 a_neg;
    logic [AW-1:0]        a_abs;
    logic [NW-1:0]        num_init;
    always_comb
    begin
        s_val    = res_reg[SW-1:0];
        a_sel    = $signed(raw_reg[comp_reg*AW +: AW]);
        a_neg    = a_sel[AW-1];
        a_abs    = a_neg ? AW'(-a_sel) : AW'(a_sel);
        num_init = NW'({a_abs, {(AF+8){1'b0}}}) + NW'(s_val >> 1);
    end

    // one division step
    logic [SW:0]   rem_sh;
    logic          q_bit;
    logic [SW-1:0] rem_step;
    logic [NW-1:0] quo_step;
    logic [AW-1:0] q_mag;
    logic [AW-1:0] u_val;
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NW-1]};
        q_bit  = (rem_sh >= {1'b0, s_val});
        rem_step = q_bit ? SW'(rem_sh - {1'b0, s_val}) : rem_sh[SW-1:0];
        quo_step = {quo_reg[NW-2:0], q_bit};
        if (quo_step > NW'(1 << AF))
            q_mag = AW'(1 << AF);
        else
            q_mag = quo_step[AW-1:0];
        if (s_val == '0)
            u_val = '0;
        else
            u_val = a_neg ? AW'(-q_mag) : q_mag;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE: if (cmd.start) state_next = N_SQRT;
            N_SQRT: if (sq_cnt_reg == SQ_LAST) state_next = N_LOAD;
            N_LOAD: state_next = N_DIV;
            N_DIV:
                if (dv_cnt_reg == DV_LAST)
                    state_next = (comp_reg == 2'd2) ? N_IDLE : N_LOAD;
            default: state_next = N_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = (state_reg != N_IDLE);
        unit_axes = u_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= N_IDLE;
            comp_reg   <= '0;
            sq_cnt_reg <= '0;
            dv_cnt_reg <= '0;
            for (int j = 0; j < 3; j++)
                for (int i = 0; i < 3; i++)
                    u_reg[j][i] <= (i == j) ? AW'(1 << AF) : '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                N_IDLE:
                    if (cmd.start)
                    begin
                        comp_reg   <= '0;
                        sq_cnt_reg <= '0;
                    end
                N_SQRT: sq_cnt_reg <= sq_cnt_reg + 1'b1;
                N_LOAD: dv_cnt_reg <= '0;
                N_DIV:
                begin
                    dv_cnt_reg <= dv_cnt_reg + 1'b1;
                    if (dv_cnt_reg == DV_LAST)
                    begin
                        u_reg[axis_reg][comp_reg] <= u_val;
                        comp_reg <= comp_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            N_IDLE:
                if (cmd.start)
                begin
                    raw_reg  <= axis_data;
                    axis_reg <= cmd.axis;
                    x_reg    <= {n_in, 16'b0};
                    res_reg  <= '0;
                    bit_reg  <= XW'(1) << (XW - 2);
                end
            N_SQRT:
            begin
                x_reg   <= x_step;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
            end
            N_LOAD:
            begin
                num_reg <= num_init;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            N_DIV:
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                rem_reg <= rem_step;
                quo_reg <= quo_step;
            end
            default: ;
        endcase
    end

endmodule

>>> design/obbcp_pipe.sv
// eight stage query pipeline: offset, projection, clamp, rebuild, round, distance
module obbcp_pipe
    import obbcp_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          point_x,
    input  logic signed [COORD_WIDTH-1:0]          point_y,
    input  logic signed [COORD_WIDTH-1:0]          point_z,
    input  logic [3*COORD_WIDTH-1:0]               center,
    input  logic [3*COORD_WIDTH-1:0]               halfs,
    input  logic [2:0][2:0][AXIS_FRAC_BITS+1:0]    unit_axes,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_WIDTH-1:0]          closest_x,
    output logic signed [COORD_WIDTH-1:0]          closest_y,
    output logic signed [COORD_WIDTH-1:0]          closest_z,
    output logic [2*COORD_WIDTH+1:0]               sq_distance
);

    localparam int CW  = COORD_WIDTH;
    localparam int AF  = AXIS_FRAC_BITS;
    localparam int AW  = AF + 2;
    localparam int DW  = CW + 1;
    localparam int P1  = DW + AW;
    localparam int DTW = P1 + 2;
    localparam int HW  = CW + AF;
    localparam int DCW = HW + 1;
    localparam int P2  = DCW + AW;
    localparam int ACW = CW + 2 * AF + 5;
    localparam int QE  = CW + 1;
    localparam int EW  = 2 * CW + 2;
    localparam int SQW = 2 * CW + 2;

    logic [8:1] v_reg;
    logic [9:1] rdy;

    always_comb
    begin
        rdy[9] = out_ready;
        for (int k = 8; k >= 1; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready = rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[1]) v_reg[1] <= in_valid;
            for (int k = 2; k <= 8; k++)
                if (rdy[k]) v_reg[k] <= v_reg[k-1];
        end
    end

    logic signed [CW-1:0]  c_f [3];
    logic signed [AW-1:0]  u_f [3][3];
    logic [CW-1:0]         h_f [3];
    logic signed [CW-1:0]  p_in [3];
    always_comb
    begin
        p_in[0] = point_x;
        p_in[1] = point_y;
        p_in[2] = point_z;
        for (int i = 0; i < 3; i++)
        begin
            c_f[i] = $signed(center[i*CW +: CW]);
            h_f[i] = halfs[i*CW +: CW];
            for (int j = 0; j < 3; j++)
                u_f[j][i] = $signed(unit_axes[j][i]);
        end
    end

    logic signed [CW-1:0]  p1_reg [3], p2_reg [3], p3_reg [3], p4_reg [3],
                           p5_reg [3], p6_reg [3];
    logic signed [DW-1:0]  dir_reg [3];
    logic signed [P1-1:0]  prod1_reg [3][3];
    logic signed [DCW-1:0] d_reg [3];
    logic signed [P2-1:0]  prod2_reg [3][3];
    logic signed [ACW-1:0] acc_reg [3];
    logic signed [CW-1:0]  q_reg [3], q7_reg [3];
    logic [EW-1:0]         esq_reg [3];
    logic signed [CW-1:0]  cx_reg, cy_reg, cz_reg;
    logic [SQW-1:0]        sq_reg;

    // clamp of the dot products to the half extents
    logic signed [DTW-1:0] dot [3];
    logic signed [DTW-1:0] hsx [3];
    logic signed [DCW-1:0] d_next [3];
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            dot[j] = DTW'(prod1_reg[j][0]) + DTW'(prod1_reg[j][1]) + DTW'(prod1_reg[j][2]);
            hsx[j] = DTW'($signed({1'b0, h_f[j], {AF{1'b0}}}));
            if (dot[j] > hsx[j])
                d_next[j] = DCW'(hsx[j]);
            else if (dot[j] < -hsx[j])
                d_next[j] = DCW'(-hsx[j]);
            else
                d_next[j] = DCW'(dot[j]);
        end
    end

    // round ties away from zero, then saturate
    localparam logic signed [ACW-1:0] C_MAX = $signed({{(ACW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [ACW-1:0] C_MIN = $signed({{(ACW-CW+1){1'b1}}, {(CW-1){1'b0}}});
    localparam logic signed [ACW-1:0] HALF  = $signed(ACW'(1) << (2 * AF - 1));
    logic signed [ACW-1:0] rnd [3], q_full [3];
    logic signed [CW-1:0]  q_next [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]    = acc_reg[i] + HALF - ACW'(acc_reg[i][ACW-1]);
            q_full[i] = rnd[i] >>> (2 * AF);
            if (q_full[i] > C_MAX)
                q_next[i] = CW'(C_MAX);
            else if (q_full[i] < C_MIN)
                q_next[i] = CW'(C_MIN);
            else
                q_next[i] = CW'(q_full[i]);
        end
    end

    logic signed [QE-1:0] e [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            e[i] = QE'(p6_reg[i]) - QE'(q_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
            for (int i = 0; i < 3; i++)
            begin
                p1_reg[i]  <= p_in[i];
                dir_reg[i] <= DW'(p_in[i]) - DW'(c_f[i]);
            end
        if (rdy[2])
            for (int j = 0; j < 3; j++)
            begin
                p2_reg[j] <= p1_reg[j];
                for (int i = 0; i < 3; i++)
                    prod1_reg[j][i] <= P1'(dir_reg[i]) * P1'(u_f[j][i]);
            end
        if (rdy[3])
            for (int j = 0; j < 3; j++)
            begin
                p3_reg[j] <= p2_reg[j];
                d_reg[j]  <= d_next[j];
            end
        if (rdy[4])
            for (int j = 0; j < 3; j++)
            begin
                p4_reg[j] <= p3_reg[j];
                for (int i = 0; i < 3; i++)
                    prod2_reg[j][i] <= P2'(d_reg[j]) * P2'(u_f[j][i]);
            end
        if (rdy[5])
            for (int i = 0; i < 3; i++)
            begin
                p5_reg[i]  <= p4_reg[i];
                acc_reg[i] <= (ACW'(c_f[i]) <<< (2 * AF)) + ACW'(prod2_reg[0][i])
                            + ACW'(prod2_reg[1][i]) + ACW'(prod2_reg[2][i]);
            end
        if (rdy[6])
            for (int i = 0; i < 3; i++)
            begin
                p6_reg[i] <= p5_reg[i];
                q_reg[i]  <= q_next[i];
            end
        if (rdy[7])
            for (int i = 0; i < 3; i++)
            begin
                q7_reg[i]  <= q_reg[i];
                esq_reg[i] <= EW'($signed(EW'(e[i])) * $signed(EW'(e[i])));
            end
        if (rdy[8])
        begin
            cx_reg <= q7_reg[0];
            cy_reg <= q7_reg[1];
            cz_reg <= q7_reg[2];
            sq_reg <= SQW'(esq_reg[0] + esq_reg[1] + esq_reg[2]);
        end
    end

    assign out_valid   = v_reg[8];
    assign closest_x   = cx_reg;
    assign closest_y   = cy_reg;
    assign closest_z   = cz_reg;
    assign sq_distance = sq_reg;

endmodule

>>> design/obb_closest_point_sq_distance.sv
// a query point passes all eight pipeline registers before its result is valid
// throughput: one point per cycle unless out_ready or normalization stalls
// an axis write starts normalization: a square root, then a load and a
// division for each component; in_ready and cfg_ready low meanwhile
// reset: box center and half extents zero, unit axes identity, pipeline empty
// top level: configuration registers, normalizer and query pipeline
module obb_closest_point_sq_distance
    import obbcp_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]                   cfg_index,
    input  logic [((3*COORD_WIDTH > 3*(AXIS_FRAC_BITS+2)) ? 3*COORD_WIDTH
                   : 3*(AXIS_FRAC_BITS+2))-1:0]    cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          point_x,
    input  logic signed [COORD_WIDTH-1:0]          point_y,
    input  logic signed [COORD_WIDTH-1:0]          point_z,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [COORD_WIDTH-1:0]          closest_x,
    output logic signed [COORD_WIDTH-1:0]          closest_y,
    output logic signed [COORD_WIDTH-1:0]          closest_z,
    output logic [2*COORD_WIDTH+1:0]               sq_distance
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = AXIS_FRAC_BITS + 2;

    logic [3*CW-1:0] center_reg, halfs_reg;
    logic            busy;
    logic            pipe_ready;
    logic            cfg_fire;
    norm_cmd_t       cmd;
    logic [2:0][2:0][AW-1:0] unit_axes;

    assign cfg_ready = !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.axis  = 2'd0;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_AXIS_RIGHT:   begin cmd.start = 1'b1; cmd.axis = 2'd0; end
                REG_AXIS_UP:      begin cmd.start = 1'b1; cmd.axis = 2'd1; end
                REG_AXIS_FORWARD: begin cmd.start = 1'b1; cmd.axis = 2'd2; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            halfs_reg  <= '0;
        end
        else if (cfg_fire)
        begin
            if (cfg_index == REG_BOX_CENTER)
                center_reg <= cfg_data[3*CW-1:0];
            if (cfg_index == REG_HALF_EXTENTS)
                halfs_reg <= cfg_data[3*CW-1:0];
        end
    end

    obbcp_norm #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .axis_data (cfg_data[3*AW-1:0]),
        .busy      (busy),
        .unit_axes (unit_axes)
    );

    assign in_ready = pipe_ready && !busy;

    obbcp_pipe #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid && !busy),
        .in_ready    (pipe_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .center      (center_reg),
        .halfs       (halfs_reg),
        .unit_axes   (unit_axes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .closest_x   (closest_x),
        .closest_y   (closest_y),
        .closest_z   (closest_z),
        .sq_distance (sq_distance)
    );

    // no query enters while axes are being normalized
    a_busy_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready)
        else $error("input accepted during normalization");

    // an axis write always starts the normalizer
    a_axis_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && (cfg_index == REG_AXIS_RIGHT || cfg_index == REG_AXIS_UP
                      || cfg_index == REG_AXIS_FORWARD)) |=> busy)
        else $error("axis write did not start normalization");

    // center and extent writes leave the normalizer idle
    a_plain_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && (cfg_index == REG_BOX_CENTER || cfg_index == REG_HALF_EXTENTS))
        |=> !busy)
        else $error("plain register write started normalization");

endmodule
